// ===== rtl/isseq_pkg.sv =====
// ----------------------------------------------------------------------------
// isseq_pkg
// Types, codes and constants shared by the interval step sequencer.
// ----------------------------------------------------------------------------
package isseq_pkg;

    localparam int MAX_STEPS_DEF = 32;
    localparam logic [4:0] MAX_WALK = 5'd31;

    localparam logic [2:0] REQ_LOAD   = 3'd0;
    localparam logic [2:0] REQ_START  = 3'd1;
    localparam logic [2:0] REQ_TICK   = 3'd2;
    localparam logic [2:0] REQ_MANUAL = 3'd3;
    localparam logic [2:0] REQ_STATUS = 3'd4;

    localparam logic [2:0] EV_STARTED      = 3'd0;
    localparam logic [2:0] EV_COMPLETED    = 3'd1;
    localparam logic [2:0] EV_LOOPED       = 3'd2;
    localparam logic [2:0] EV_REP_DONE     = 3'd3;
    localparam logic [2:0] EV_WORKOUT_DONE = 3'd4;
    localparam logic [2:0] EV_STATUS       = 3'd5;

    localparam logic [1:0] KIND_TIME   = 2'd0;
    localparam logic [1:0] KIND_DIST   = 2'd1;
    localparam logic [1:0] KIND_OPEN   = 2'd2;
    localparam logic [1:0] KIND_MARKER = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  load_index;
        logic [1:0]  step_kind;
        logic [31:0] step_value;
        logic [15:0] step_repeat;
        logic [31:0] now_ms;
        logic [31:0] distance_cm;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [4:0]  event_step;
        logic [15:0] iterations_left;
        logic [31:0] elapsed_ms;
        logic [31:0] remaining_ms;
        logic        running;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [15:0] repeat_cnt;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CUR_RD,
        S_CUR_CHK,
        S_WALK_TEST,
        S_WALK_CHK
    } t_state;

endpackage

// ===== rtl/isseq_table.sv =====
// ----------------------------------------------------------------------------
// isseq_table
// Step table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module isseq_table #(
    parameter int MAX_STEPS = isseq_pkg::MAX_STEPS_DEF,
    parameter int IW        = $clog2(MAX_STEPS)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IW-1:0]     i_wr_addr,
    input  isseq_pkg::t_entry i_wr_data,
    input  logic [IW-1:0]     i_rd_addr,
    output isseq_pkg::t_entry o_rd_data
);
    import isseq_pkg::*;

    t_entry r_mem [MAX_STEPS];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

// ===== rtl/isseq_core.sv =====
// ----------------------------------------------------------------------------
// isseq_core
// Request sequencer: decodes a request, reads the table, checks step end
// and walks repeat markers one table read at a time.
// ----------------------------------------------------------------------------
module isseq_core #(
    parameter int MAX_STEPS = isseq_pkg::MAX_STEPS_DEF,
    parameter int IW        = $clog2(MAX_STEPS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  isseq_pkg::t_in    i_in,
    input  logic [5:0]        i_step_count,
    input  logic              i_out_free,
    output logic              o_emit,
    output isseq_pkg::t_out   o_ev,
    output logic              o_wr_en,
    output logic [IW-1:0]     o_wr_addr,
    output isseq_pkg::t_entry o_wr_data,
    output logic [IW-1:0]     o_rd_addr,
    input  isseq_pkg::t_entry i_rd_data
);
    import isseq_pkg::*;

    t_state r_state, n_state;
    t_in    r_req;
    logic [IW-1:0] r_cur, n_cur;
    logic [31:0]   r_t0, n_t0, r_d0, n_d0;
    logic          r_act, n_act;
    logic [IW-1:0] r_mark, n_mark;
    logic [15:0]   r_loops, n_loops;
    logic          r_started, n_started, r_done, n_done;
    logic [31:0]   r_next, n_next;
    logic [4:0]    r_walked, n_walked;
    logic [31:0]   r_el, n_el, r_dd, n_dd;

    logic [7:0]  w_cnt, w_ld, w_cur8, w_nxt8;
    logic        w_acc, w_run, w_tdone, w_in_range;
    logic [15:0] w_base, w_dec;

    assign w_cnt  = (8'(i_step_count) < 8'(MAX_STEPS)) ? 8'(i_step_count) : 8'(MAX_STEPS);
    assign w_ld   = 8'(i_in.load_index);
    assign w_cur8 = 8'(r_cur);
    assign w_nxt8 = 8'(r_next[IW-1:0]);
    assign w_acc  = i_in_valid && o_in_ready;
    assign w_run  = r_started && !r_done;
    assign w_in_range = r_next < 32'(w_cnt);

    assign o_in_ready = (r_state == S_IDLE);
    assign o_wr_en    = w_acc && (i_in.req_type == REQ_LOAD) && (w_ld < 8'(MAX_STEPS));
    assign o_wr_addr  = w_ld[IW-1:0];
    assign o_wr_data  = '{kind: i_in.step_kind, value: i_in.step_value,
                          repeat_cnt: i_in.step_repeat};
    assign o_rd_addr  = (r_state == S_WALK_TEST || r_state == S_WALK_CHK)
                        ? r_next[IW-1:0] : r_cur;

    // step end test on a tick
    always_comb begin
        case (i_rd_data.kind)
            KIND_TIME: w_tdone = r_el >= i_rd_data.value;
            KIND_DIST: w_tdone = r_dd >= i_rd_data.value;
            default:   w_tdone = 1'b0;
        endcase
    end

    assign w_base = (r_act && r_mark == r_next[IW-1:0]) ? r_loops :
                    ((i_rd_data.repeat_cnt != 16'd0) ? i_rd_data.repeat_cnt : 16'd1);
    assign w_dec  = w_base - 16'd1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_in.req_type)
                        REQ_START:  n_state = S_START;
                        REQ_TICK, REQ_MANUAL, REQ_STATUS: n_state = S_CUR_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_START: begin
                if (i_out_free) n_state = S_IDLE;
            end
            S_CUR_RD: n_state = S_CUR_CHK;
            S_CUR_CHK: begin
                if (r_req.req_type == REQ_STATUS) begin
                    if (i_out_free) n_state = S_IDLE;
                end else if (!w_run) begin
                    n_state = S_IDLE;
                end else if (r_req.req_type == REQ_MANUAL || w_tdone) begin
                    if (i_out_free) n_state = S_WALK_TEST;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WALK_TEST: begin
                if (!w_in_range) begin
                    if (i_out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                if (i_out_free) begin
                    if (i_rd_data.kind != KIND_MARKER || r_walked == MAX_WALK) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_WALK_TEST;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and events
    always_comb begin
        n_cur = r_cur; n_t0 = r_t0; n_d0 = r_d0;
        n_act = r_act; n_mark = r_mark; n_loops = r_loops;
        n_started = r_started; n_done = r_done;
        n_next = r_next; n_walked = r_walked;
        n_el = r_req.now_ms - r_t0;
        n_dd = r_req.distance_cm - r_d0;
        o_emit = 1'b0;
        o_ev = '0;
        case (r_state)
            S_START: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    o_ev.last = 1'b1;
                    n_act = 1'b0; n_loops = '0; n_started = 1'b1; n_cur = '0;
                    if (w_cnt == 8'd0) begin
                        n_done = 1'b1;
                        o_ev.event_kind = EV_WORKOUT_DONE;
                    end else begin
                        n_done = 1'b0;
                        n_t0 = r_req.now_ms;
                        n_d0 = r_req.distance_cm;
                        o_ev.event_kind = EV_STARTED;
                    end
                end
            end
            S_CUR_CHK: begin
                if (r_req.req_type == REQ_STATUS) begin
                    o_emit = i_out_free;
                    o_ev.event_kind = EV_STATUS;
                    o_ev.iterations_left = r_act ? r_loops : 16'd0;
                    o_ev.running = w_run;
                    o_ev.last = 1'b1;
                    if (w_run) begin
                        o_ev.event_step = w_cur8[4:0];
                        o_ev.elapsed_ms = r_el;
                        if (i_rd_data.kind == KIND_TIME && r_el < i_rd_data.value) begin
                            o_ev.remaining_ms = i_rd_data.value - r_el;
                        end
                    end
                end else if (w_run && (r_req.req_type == REQ_MANUAL || w_tdone)) begin
                    o_emit = i_out_free;
                    o_ev.event_kind = EV_COMPLETED;
                    o_ev.event_step = w_cur8[4:0];
                    n_next = 32'(w_cur8) + 32'd1;
                    n_walked = '0;
                end
            end
            S_WALK_TEST: begin
                if (!w_in_range && i_out_free) begin
                    o_emit = 1'b1;
                    o_ev.event_kind = EV_WORKOUT_DONE;
                    o_ev.last = 1'b1;
                    n_done = 1'b1;
                end
            end
            S_WALK_CHK: begin
                if (i_out_free) begin
                    o_emit = 1'b1;
                    if (i_rd_data.kind != KIND_MARKER) begin
                        o_ev.event_kind = EV_STARTED;
                        o_ev.event_step = w_nxt8[4:0];
                        o_ev.last = 1'b1;
                        n_cur = r_next[IW-1:0];
                        n_t0 = r_req.now_ms;
                        n_d0 = r_req.distance_cm;
                    end else if (r_walked == MAX_WALK) begin
                        // runaway chain: give up and finish
                        o_ev.event_kind = EV_WORKOUT_DONE;
                        o_ev.last = 1'b1;
                        n_done = 1'b1;
                    end else begin
                        n_walked = r_walked + 5'd1;
                        o_ev.event_step = w_nxt8[4:0];
                        if (w_dec != 16'd0) begin
                            n_act = 1'b1;
                            n_mark = r_next[IW-1:0];
                            n_loops = w_dec;
                            o_ev.event_kind = EV_LOOPED;
                            o_ev.iterations_left = w_dec;
                            n_next = i_rd_data.value;
                        end else begin
                            n_act = 1'b0;
                            n_loops = w_dec;
                            o_ev.event_kind = EV_REP_DONE;
                            n_next = r_next + 32'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_t0      <= '0;
            r_d0      <= '0;
            r_act     <= 1'b0;
            r_mark    <= '0;
            r_loops   <= '0;
            r_started <= 1'b0;
            r_done    <= 1'b0;
            r_next    <= '0;
            r_walked  <= '0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_t0      <= n_t0;
            r_d0      <= n_d0;
            r_act     <= n_act;
            r_mark    <= n_mark;
            r_loops   <= n_loops;
            r_started <= n_started;
            r_done    <= n_done;
            r_next    <= n_next;
            r_walked  <= n_walked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req <= i_in;
        end
        if (r_state == S_CUR_RD) begin
            r_el <= n_el;
            r_dd <= n_dd;
        end
    end

endmodule

// ===== rtl/interval_step_sequencer.sv =====
// ----------------------------------------------------------------------------
// interval_step_sequencer
// Runs a loaded program of timed, distance, open and repeat-marker steps.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_ready is low while it is in work.
// A load or unknown request is done in S_IDLE, a start in S_START, a tick
// or status query in S_CUR_RD then S_CUR_CHK; emitting states wait on a
// stalled output. A step that ends walks S_WALK_TEST and S_WALK_CHK for
// each table entry after it (each repeat marker and the step entered),
// and ends the workout past the program end. It is bounded by the single
// table read port and one event per cycle into the output if not stalled
module interval_step_sequencer #(
    parameter int MAX_STEPS = isseq_pkg::MAX_STEPS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  isseq_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output isseq_pkg::t_out o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [5:0]      i_cfg_data
);
    import isseq_pkg::*;

    localparam int IW = $clog2(MAX_STEPS);

    logic [5:0]    r_step_count;
    logic          r_ovalid;
    t_out          r_out;
    logic          w_emit, w_free, w_wr_en;
    t_out          w_ev;
    logic [IW-1:0] w_wr_addr, w_rd_addr;
    t_entry        w_wr_data, w_rd_data;

    assign o_cfg_ready = 1'b1;
    assign w_free      = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_valid) r_step_count <= i_cfg_data;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) r_out <= w_ev;
    end

    isseq_core #(.MAX_STEPS(MAX_STEPS), .IW(IW)) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_step_count (r_step_count),
        .i_out_free   (w_free),
        .o_emit       (w_emit),
        .o_ev         (w_ev),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_rd_addr    (w_rd_addr),
        .i_rd_data    (w_rd_data)
    );

    isseq_table #(.MAX_STEPS(MAX_STEPS), .IW(IW)) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule

// ===== rtl/isseq_chk.sv =====
// ----------------------------------------------------------------------------
// isseq_chk
// Port-level checks for the interval step sequencer, bound to the top.
// ----------------------------------------------------------------------------
module isseq_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input isseq_pkg::t_in  i_in,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input isseq_pkg::t_out o_out
);
    import isseq_pkg::*;

    // a transfer that needs work closes the input until it is done
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in.req_type == REQ_START ||
        i_in.req_type == REQ_TICK || i_in.req_type == REQ_MANUAL ||
        i_in.req_type == REQ_STATUS) |=> !o_in_ready)
        else $error("input ready after working request");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output dropped or changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.event_kind != EV_STATUS |->
        o_out.elapsed_ms == 32'd0 && o_out.remaining_ms == 32'd0 && !o_out.running)
        else $error("status fields on a non-status event");

    a_stlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.event_kind == EV_STATUS ||
        o_out.event_kind == EV_WORKOUT_DONE || o_out.event_kind == EV_STARTED)
        |-> o_out.last)
        else $error("final event without last");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind interval_step_sequencer isseq_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
